@@ rtl/core/paqi_pkg.sv @@
// ----------------------------------------------------------------------------
// paqi_pkg
// Shared types, widths and breakpoint tables for the particulate index block.
// ----------------------------------------------------------------------------
`default_nettype none

package paqi_pkg;

	localparam int LEVEL_W       = 16;
	localparam int INDEX_W       = 10;
	localparam int TABLE_ROWS    = 16;
	localparam int SEGMENT_COUNT = 7;
	localparam int SEARCH_ROWS   = (SEGMENT_COUNT < TABLE_ROWS) ? SEGMENT_COUNT : TABLE_ROWS;
	localparam int ROW_W         = $clog2(TABLE_ROWS);

	// segment geometry bounds: span <= 150, rise <= 99, top index 500
	localparam int BKPT_W  = 10;
	localparam int OFF_W   = 8;
	localparam int RISE_W  = 7;
	localparam int BASE_W  = 9;
	localparam int PROD_W  = OFF_W + RISE_W;
	localparam int RECIP_W = 21;
	localparam int FULL_W  = PROD_W + RECIP_W;
	// reciprocal scale: recip = ceil(2^RECIP_SHIFT / span), exact for prod < 2^15
	localparam int RECIP_SHIFT = 24;
	localparam int QUOT_W  = RISE_W;

	typedef struct packed {
		logic [BKPT_W-1:0]  lo;
		logic [BKPT_W-1:0]  hi;
		logic [BASE_W-1:0]  base;
		logic [RISE_W-1:0]  rise;
		logic [RECIP_W-1:0] recip;
	} paqi_seg_t;

	typedef paqi_seg_t paqi_tab_t [TABLE_ROWS];

	// stage advance strobes shared by both lanes
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
	} paqi_adv_t;

	// PM2.5 breakpoints; unused rows have lo == hi and never match
	localparam paqi_tab_t FINE_TAB = '{
		0: '{10'd0,   10'd12,  9'd0,   7'd50, 21'd1398102},
		1: '{10'd12,  10'd35,  9'd51,  7'd49, 21'd729445},
		2: '{10'd35,  10'd55,  9'd101, 7'd49, 21'd838861},
		3: '{10'd55,  10'd150, 9'd151, 7'd49, 21'd176603},
		4: '{10'd150, 10'd250, 9'd201, 7'd99, 21'd167773},
		5: '{10'd250, 10'd350, 9'd301, 7'd99, 21'd167773},
		6: '{10'd350, 10'd500, 9'd401, 7'd99, 21'd111849},
		default: '0
	};

	// PM10 breakpoints
	localparam paqi_tab_t COARSE_TAB = '{
		0: '{10'd0,   10'd54,  9'd0,   7'd50, 21'd310690},
		1: '{10'd54,  10'd154, 9'd51,  7'd49, 21'd167773},
		2: '{10'd154, 10'd254, 9'd101, 7'd49, 21'd167773},
		3: '{10'd254, 10'd354, 9'd151, 7'd49, 21'd167773},
		4: '{10'd354, 10'd424, 9'd201, 7'd99, 21'd239675},
		5: '{10'd424, 10'd504, 9'd301, 7'd99, 21'd209716},
		6: '{10'd504, 10'd604, 9'd401, 7'd99, 21'd167773},
		default: '0
	};

endpackage

`default_nettype wire

@@ rtl/core/particulate_aqi_index.sv @@
// ----------------------------------------------------------------------------
// particulate_aqi_index
// PM2.5 / PM10 readings to piecewise-linear air quality sub-indices.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with pm25_level and pm10_level (ug/m3).
// Output channel: out_valid / out_stall with pm25_index, pm10_index and
// overall_index, all 10-bit signed; -1 marks a reading at or above the top
// breakpoint. One result per request.
// Pipeline: four register stages (segment search, offset * rise, reciprocal
// multiply, output register).
// Throughput: one request per cycle while the output is not stalled; the two
// multiplier stages of each lane are fully pipelined.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles are squeezed out while the receiver stalls; in_stall rises only
// when every stage holds a request and the output is stalled.
// Reset clears all valid flags; no request is in flight afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module particulate_aqi_index
	import paqi_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [LEVEL_W-1:0]        pm25_level,
	input  wire logic [LEVEL_W-1:0]        pm10_level,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic signed [INDEX_W-1:0]      pm25_index,
	output logic signed [INDEX_W-1:0]      pm10_index,
	output logic signed [INDEX_W-1:0]      overall_index
);

	paqi_adv_t adv;
	logic      en_s1;
	logic      en_s2;
	logic      en_s3;
	logic      en_out;
	logic      valid_s1;
	logic      valid_s2;
	logic      valid_s3;
	logic      out_valid_q;

	logic signed [INDEX_W-1:0] fine_index;
	logic signed [INDEX_W-1:0] coarse_index;

	assign en_out     = !out_valid_q || !out_stall;
	assign en_s3      = !valid_s3 || en_out;
	assign en_s2      = !valid_s2 || en_s3;
	assign en_s1      = !valid_s1 || en_s2;
	assign adv        = {en_s1, en_s2, en_s3};
	assign in_stall   = !en_s1;
	assign out_valid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1)  valid_s1 <= in_valid;
			if (en_s2)  valid_s2 <= valid_s1;
			if (en_s3)  valid_s3 <= valid_s2;
			if (en_out) out_valid_q <= valid_s3;
		end
	end

	paqi_lane u_lane_pm25 (
		.clk       (clk),
		.coarse    (1'b0),
		.adv       (adv),
		.level     (pm25_level),
		.sub_index (fine_index)
	);

	paqi_lane u_lane_pm10 (
		.clk       (clk),
		.coarse    (1'b1),
		.adv       (adv),
		.level     (pm10_level),
		.sub_index (coarse_index)
	);

	paqi_merge u_merge (
		.clk           (clk),
		.load          (en_out),
		.fine_index    (fine_index),
		.coarse_index  (coarse_index),
		.pm25_index    (pm25_index),
		.pm10_index    (pm10_index),
		.overall_index (overall_index)
	);

	// input backs up only when the whole pipe is full and the output is held
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall && valid_s1 && valid_s2 && valid_s3))
		else $error("in_stall with room in the pipeline");

	// a finished request moves to the output whenever the output can take it
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && en_out) |=> out_valid)
		else $error("stage 3 request lost");

	// overall index tracks the larger sub-index
	a_overall_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (overall_index == ((pm25_index > pm10_index) ? pm25_index : pm10_index)))
		else $error("overall_index is not the larger sub-index");

endmodule

`default_nettype wire

@@ rtl/core/paqi_lane.sv @@
// ----------------------------------------------------------------------------
// paqi_lane
// One pollutant lane: segment search, offset times rise, reciprocal divide.
// ----------------------------------------------------------------------------
`default_nettype none

module paqi_lane
	import paqi_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      coarse,
	input  wire paqi_adv_t                 adv,
	input  wire logic [LEVEL_W-1:0]        level,
	output logic signed [INDEX_W-1:0]      sub_index
);

	paqi_seg_t            seg;
	logic                 hit;
	logic [LEVEL_W-1:0]   diff;

	logic [OFF_W-1:0]     off_s1;
	logic [RISE_W-1:0]    rise_s1;
	logic [RECIP_W-1:0]   recip_s1;
	logic [BASE_W-1:0]    base_s1;
	logic                 hit_s1;

	logic [PROD_W-1:0]    prod_s2;
	logic [RECIP_W-1:0]   recip_s2;
	logic [BASE_W-1:0]    base_s2;
	logic                 hit_s2;

	logic [FULL_W-1:0]    full;
	logic [QUOT_W-1:0]    quot;
	logic signed [INDEX_W-1:0] sub_s3;

	// first matching segment wins: scan from the top down
	always_comb begin
		paqi_seg_t row;
		seg = '0;
		hit = 1'b0;
		for (int i = SEARCH_ROWS - 1; i >= 0; i--) begin
			row = coarse ? COARSE_TAB[ROW_W'(i)] : FINE_TAB[ROW_W'(i)];
			if (level >= LEVEL_W'(row.lo) && level < LEVEL_W'(row.hi)) begin
				seg = row;
				hit = 1'b1;
			end
		end
	end

	assign diff = level - LEVEL_W'(seg.lo);

	always_ff @(posedge clk) begin
		if (adv.en_s1) begin
			off_s1   <= diff[OFF_W-1:0];
			rise_s1  <= seg.rise;
			recip_s1 <= seg.recip;
			base_s1  <= seg.base;
			hit_s1   <= hit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.en_s2) begin
			prod_s2  <= PROD_W'(off_s1) * PROD_W'(rise_s1);
			recip_s2 <= recip_s1;
			base_s2  <= base_s1;
			hit_s2   <= hit_s1;
		end
	end

	assign full = FULL_W'(prod_s2) * FULL_W'(recip_s2);
	assign quot = full[RECIP_SHIFT +: QUOT_W];

	always_ff @(posedge clk) begin
		if (adv.en_s3) begin
			if (hit_s2) begin
				sub_s3 <= signed'(INDEX_W'(base_s2) + INDEX_W'(quot));
			end else begin
				sub_s3 <= '1;
			end
		end
	end

	assign sub_index = sub_s3;

endmodule

`default_nettype wire

@@ rtl/core/paqi_merge.sv @@
// ----------------------------------------------------------------------------
// paqi_merge
// Output register: holds both sub-indices and the larger of the two.
// ----------------------------------------------------------------------------
`default_nettype none

module paqi_merge
	import paqi_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      load,
	input  wire logic signed [INDEX_W-1:0] fine_index,
	input  wire logic signed [INDEX_W-1:0] coarse_index,
	output logic signed [INDEX_W-1:0]      pm25_index,
	output logic signed [INDEX_W-1:0]      pm10_index,
	output logic signed [INDEX_W-1:0]      overall_index
);

	logic signed [INDEX_W-1:0] pm25_q;
	logic signed [INDEX_W-1:0] pm10_q;
	logic signed [INDEX_W-1:0] top_q;

	always_ff @(posedge clk) begin
		if (load) begin
			pm25_q <= fine_index;
			pm10_q <= coarse_index;
			top_q  <= (fine_index > coarse_index) ? fine_index : coarse_index;
		end
	end

	assign pm25_index    = pm25_q;
	assign pm10_index    = pm10_q;
	assign overall_index = top_q;

endmodule

`default_nettype wire
